[rtl/core/ffra_pkg.sv]
// Package: shared types, constants and command/status structs of the region allocator.
`default_nettype none
package ffra_pkg;
   localparam int unsigned MaxRegionsDefault = 16;
   localparam logic [31:0] FirstBase = 32'h0000_0800;
   localparam logic [31:0] EmptyTail = 32'h0000_0900;
   localparam logic [31:0] TopReset = 32'h0010_0000;
   localparam logic [31:0] LengthReset = 32'h0000_0100;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_QUERY  = 2'd1,
      OP_FREE   = 2'd2,
      OP_SHRINK = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_BASE  = 2'd1,
      ST_GROW     = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      CSR_TOP    = 1'b0,
      CSR_LENGTH = 1'b1
   } csr_index_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // take request fields, clear scan state
      logic scan;      // read entry idx, evaluate
      logic shift_up;  // move entry idx-1 to idx
      logic shift_dn;  // move entry idx+1 to idx
      logic write_new; // write base/len at idx
      logic write_len; // write len at idx
      logic cnt_inc;
      logic cnt_dec;
      logic idx_inc;
      logic idx_dec;
      logic idx_to_cnt;
      logic reload;    // table back to single first region
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done;  // idx reached count
      logic hit;        // scan condition met at idx
      logic at_pos;     // idx equals insert position
      logic last;       // idx+1 >= count
      logic full;
      logic too_big;
      logic tail_fit;
      logic len_lt;
   } stat_type;
endpackage
`default_nettype wire

[rtl/core/ffra_if.sv]
// Interfaces: request, response and register write channels.
`default_nettype none
interface ffra_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [31:0] request_size;
   logic [31:0] block_address;
   modport source (output valid, opcode, request_size, block_address, input ready);
   modport sink (input valid, opcode, request_size, block_address, output ready);
endinterface

interface ffra_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_value;
   logic [1:0]  status;
   modport source (output valid, result_value, status, input ready);
   modport sink (input valid, result_value, status, output ready);
endinterface

interface ffra_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/ffra_datapath.sv]
// Datapath: region table, registers, scan arithmetic and result.
`default_nettype none
module ffra_datapath
   import ffra_pkg::*;
#(
   parameter int unsigned MAX_REGIONS = MaxRegionsDefault,
   localparam int unsigned IW = $clog2(MAX_REGIONS),
   localparam int unsigned CW = $clog2(MAX_REGIONS + 1)
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   input  wire logic [1:0]  op,
   input  wire logic [31:0] req_size,
   input  wire logic [31:0] req_addr,
   input  wire logic        top_we,
   input  wire logic [31:0] csr_data,
   output logic [31:0]      scan_value,
   output logic [31:0]      tail_value
);
   logic [31:0] base_ff [MAX_REGIONS];
   logic [31:0] len_ff [MAX_REGIONS];
   logic [31:0] top_ff;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] idx_ff;
   logic [31:0] size_ff, addr_ff, prev_end_ff, best_ff, pos_base_ff;
   logic [CW-1:0] pos_ff;
   logic [IW-1:0] ia, im, ip;
   logic [31:0] cur_base, cur_len, cur_end, gap, tail;

   assign ia = idx_ff[IW-1:0];
   assign im = IW'(idx_ff - CW'(1));
   assign ip = IW'(idx_ff + CW'(1));
   assign cur_base = base_ff[ia];
   assign cur_len = len_ff[ia];
   assign cur_end = cur_base + cur_len;
   assign gap = cur_base - prev_end_ff;
   assign tail = (cnt_ff == '0) ? EmptyTail : prev_end_ff;

   always_comb begin
      stat.scan_done = (idx_ff >= cnt_ff);
      stat.at_pos = (idx_ff == pos_ff);
      stat.last = ((idx_ff + CW'(1)) >= cnt_ff);
      stat.full = (cnt_ff >= CW'(MAX_REGIONS));
      stat.too_big = size_ff[31];
      stat.tail_fit = size_ff < (top_ff - tail);
      stat.len_lt = cur_len < size_ff;
      case (op)
         OP_ALLOC: stat.hit = (idx_ff != '0) && (gap > size_ff);
         OP_QUERY: stat.hit = 1'b0;
         default:  stat.hit = (cur_base == addr_ff);
      endcase
   end

   assign scan_value = (op == OP_QUERY) ? best_ff : pos_base_ff;
   assign tail_value = top_ff - tail;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= TopReset;
      end else if (top_we) begin
         top_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.reload) begin
         cnt_ff <= CW'(1);
      end else if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff[0] <= FirstBase;
         len_ff[0] <= LengthReset;
      end else if (cmd.reload) begin
         base_ff[0] <= FirstBase;
         len_ff[0] <= csr_data;
      end else if (cmd.shift_up) begin
         base_ff[ia] <= base_ff[im];
         len_ff[ia] <= len_ff[im];
      end else if (cmd.shift_dn) begin
         base_ff[ia] <= base_ff[ip];
         len_ff[ia] <= len_ff[ip];
      end else if (cmd.write_new) begin
         base_ff[ia] <= pos_base_ff;
         len_ff[ia] <= size_ff;
      end else if (cmd.write_len) begin
         len_ff[ia] <= size_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff <= '0;
         size_ff <= req_size;
         addr_ff <= req_addr;
         prev_end_ff <= EmptyTail;
         best_ff <= '0;
         pos_base_ff <= '0;
      end else begin
         if (cmd.scan) begin
            prev_end_ff <= cur_end;
            if (idx_ff != '0 && gap > best_ff) best_ff <= gap;
            if (stat.hit) begin
               pos_ff <= idx_ff;
               pos_base_ff <= prev_end_ff;
            end
         end
         if (cmd.idx_to_cnt) begin
            idx_ff <= cnt_ff;
            if (stat.scan_done) begin
               pos_ff <= cnt_ff;
               pos_base_ff <= tail;
            end
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + CW'(1);
         end else if (cmd.idx_dec) begin
            idx_ff <= idx_ff - CW'(1);
         end
      end
   end
endmodule
`default_nettype wire

[rtl/core/ffra_control.sv]
// Controller: sequences scan, shift and response for each transaction.
`default_nettype none
module ffra_control
   import ffra_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   ffra_req_if.sink         req,
   ffra_rsp_if.source       rsp,
   ffra_csr_if.sink         csr,
   output cmd_type          cmd,
   input  wire stat_type    stat,
   output logic [1:0]       op,
   output logic             top_we,
   input  wire logic [31:0] scan_value,
   input  wire logic [31:0] tail_value
);
   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_TAIL, S_SHIFT_UP, S_SHIFT_DN, S_RESP
   } state_type;

   state_type state_ff;
   logic [1:0] op_ff;
   logic [31:0] value_ff;
   logic [1:0] status_ff;

   assign op = op_ff;
   assign req.ready = (state_ff == S_IDLE) && !csr.valid;
   assign csr.ready = (state_ff == S_IDLE);
   assign top_we = csr.valid && csr.ready && (csr.index == CSR_TOP);
   assign rsp.valid = (state_ff == S_RESP);
   assign rsp.result_value = value_ff;
   assign rsp.status = status_ff;

   always_comb begin
      cmd = '0;
      cmd.reload = csr.valid && csr.ready && (csr.index == CSR_LENGTH);
      cmd.load = req.valid && req.ready;
      case (state_ff)
         S_SCAN: begin
            if (stat.scan_done) begin
               cmd.idx_to_cnt = 1'b1;
            end else begin
               cmd.scan = 1'b1;
               if (!stat.hit) cmd.idx_inc = 1'b1;
               else if (op_ff != OP_FREE) cmd.idx_to_cnt = 1'b1;
               if (stat.hit && op_ff == OP_SHRINK && !stat.len_lt) cmd.write_len = 1'b1;
            end
         end
         S_SHIFT_UP: begin
            if (stat.at_pos) begin
               cmd.write_new = 1'b1;
               cmd.cnt_inc = 1'b1;
            end else begin
               cmd.shift_up = 1'b1;
               cmd.idx_dec = 1'b1;
            end
         end
         S_SHIFT_DN: begin
            if (stat.last) cmd.cnt_dec = 1'b1;
            else begin
               cmd.shift_dn = 1'b1;
               cmd.idx_inc = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff <= OP_ALLOC;
         value_ff <= '0;
         status_ff <= ST_OK;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  op_ff <= req.opcode;
                  value_ff <= '0;
                  status_ff <= ST_OK;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (op_ff == OP_ALLOC && (stat.too_big || stat.full)) begin
                  state_ff <= S_RESP;
               end else if (stat.scan_done) begin
                  state_ff <= S_TAIL;
                  if (op_ff == OP_FREE || op_ff == OP_SHRINK) begin
                     status_ff <= ST_NO_BASE;
                     state_ff <= S_RESP;
                  end
               end else if (stat.hit) begin
                  case (op_ff)
                     OP_ALLOC: state_ff <= S_TAIL;
                     OP_FREE: state_ff <= S_SHIFT_DN;
                     default: begin
                        if (stat.len_lt) status_ff <= ST_GROW;
                        state_ff <= S_RESP;
                     end
                  endcase
               end
            end
            S_TAIL: begin
               if (op_ff == OP_QUERY) begin
                  value_ff <= (tail_value > scan_value) ? tail_value : scan_value;
                  state_ff <= S_RESP;
               end else if (stat.at_pos && !stat.tail_fit) begin
                  state_ff <= S_RESP;
               end else begin
                  value_ff <= scan_value;
                  state_ff <= S_SHIFT_UP;
               end
            end
            S_SHIFT_UP: if (stat.at_pos) state_ff <= S_RESP;
            S_SHIFT_DN: if (stat.last) state_ff <= S_RESP;
            S_RESP: if (rsp.ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.result_value))
      else $error("response dropped");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req.ready)
      else $error("accept while busy");
   a_one_shift: assert property (@(posedge clock) disable iff (reset)
      !(cmd.shift_up && cmd.shift_dn))
      else $error("conflicting shifts");
`endif
endmodule
`default_nettype wire

[rtl/core/first_fit_region_allocator.sv]
// Top level: first-fit region allocator.
// Keeps up to MAX_REGIONS (base, length) regions sorted by base. One transaction at a time:
// an operation scans the table in order, one entry per cycle, shifts table entries on
// allocate or free, and then presents a response. Register writes are taken only while idle.
`default_nettype none
module first_fit_region_allocator
   import ffra_pkg::*;
#(
   parameter int unsigned MAX_REGIONS = MaxRegionsDefault
) (
   input wire logic   clock,
   input wire logic   reset,
   ffra_req_if.sink   req,
   ffra_rsp_if.source rsp,
   ffra_csr_if.sink   csr
);
   cmd_type cmd;
   stat_type stat;
   logic [1:0] op;
   logic top_we;
   logic [31:0] scan_value, tail_value;

   ffra_control u_ctrl (
      .clock, .reset, .req, .rsp, .csr, .cmd, .stat, .op, .top_we,
      .scan_value, .tail_value
   );

   ffra_datapath #(.MAX_REGIONS(MAX_REGIONS)) u_dp (
      .clock, .reset, .cmd, .stat, .op,
      .req_size(req.request_size), .req_addr(req.block_address),
      .top_we, .csr_data(csr.data), .scan_value, .tail_value
   );
endmodule
`default_nettype wire

[test/tb_ffra_pkg.sv]
// Package: testbench transaction types shared by the allocator test.
package tb_ffra_pkg;
   import ffra_pkg::*;

   typedef struct {
      opcode_type  opcode;
      logic [31:0] request_size;
      logic [31:0] block_address;
   } alloc_cmd_type;

   typedef struct {
      logic [31:0] result_value;
      status_type  status;
   } alloc_rsp_type;
endpackage

[test/tb_first_fit_region_allocator.sv]
// Testbench: drives the first-fit region allocator and checks every response against a model.
module tb_first_fit_region_allocator;
   import ffra_pkg::*;
   import tb_ffra_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned Depth = 16;
   localparam logic [31:0] SizeLimit = 32'h8000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ffra_req_if req ();
   ffra_rsp_if rsp ();
   ffra_csr_if csr ();

   first_fit_region_allocator #(.MAX_REGIONS(Depth)) dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   logic [31:0] mdl_top;
   logic [31:0] mdl_init_len;
   logic [31:0] mdl_base [Depth];
   logic [31:0] mdl_len [Depth];
   int unsigned mdl_count;

   alloc_rsp_type pending_rsp [$];
   int unsigned n_errors = 0;
   int unsigned n_sent = 0;
   int unsigned n_checked = 0;
   int unsigned n_alloc_ok = 0;
   int unsigned n_full = 0;
   int unsigned op_seen [4];
   bit          stall_en = 1'b1;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("first_fit_region_allocator test failed");
      $finish;
   end

   function automatic void table_reload();
      for (int i = 0; i < Depth; i++) begin
         mdl_base[i] = '0;
         mdl_len[i] = '0;
      end
      mdl_base[0] = FirstBase;
      mdl_len[0] = mdl_init_len;
      mdl_count = 1;
   endfunction

   function automatic logic [31:0] tail_end();
      if (mdl_count == 0) begin
         return EmptyTail;
      end
      return mdl_base[mdl_count-1] + mdl_len[mdl_count-1];
   endfunction

   function automatic void table_insert(int unsigned pos, logic [31:0] b, logic [31:0] l);
      for (int i = mdl_count; i > pos; i--) begin
         mdl_base[i] = mdl_base[i-1];
         mdl_len[i] = mdl_len[i-1];
      end
      mdl_base[pos] = b;
      mdl_len[pos] = l;
      mdl_count++;
   endfunction

   function automatic alloc_rsp_type predict_region_op(alloc_cmd_type c);
      alloc_rsp_type r;
      logic [31:0] start;
      logic [31:0] gap;
      int unsigned i;
      r.result_value = '0;
      r.status = ST_OK;
      case (c.opcode)
         OP_ALLOC: begin
            if (mdl_count >= Depth) begin
               n_full++;
            end
            if (c.request_size < SizeLimit && mdl_count < Depth) begin
               for (i = 1; i < mdl_count; i++) begin
                  start = mdl_base[i-1] + mdl_len[i-1];
                  if (mdl_base[i] - start > c.request_size) begin
                     table_insert(i, start, c.request_size);
                     r.result_value = start;
                     n_alloc_ok++;
                     return r;
                  end
               end
               start = tail_end();
               if (c.request_size < mdl_top - start) begin
                  table_insert(mdl_count, start, c.request_size);
                  r.result_value = start;
                  n_alloc_ok++;
               end
            end
         end
         OP_QUERY: begin
            for (i = 1; i < mdl_count; i++) begin
               gap = mdl_base[i] - (mdl_base[i-1] + mdl_len[i-1]);
               if (gap > r.result_value) begin
                  r.result_value = gap;
               end
            end
            gap = mdl_top - tail_end();
            if (gap > r.result_value) begin
               r.result_value = gap;
            end
         end
         default: begin
            for (i = 0; i < mdl_count; i++) begin
               if (mdl_base[i] == c.block_address) begin
                  break;
               end
            end
            if (i >= mdl_count) begin
               r.status = ST_NO_BASE;
            end else if (c.opcode == OP_FREE) begin
               for (; i + 1 < mdl_count; i++) begin
                  mdl_base[i] = mdl_base[i+1];
                  mdl_len[i] = mdl_len[i+1];
               end
               mdl_count--;
            end else if (mdl_len[i] < c.request_size) begin
               r.status = ST_GROW;
            end else begin
               mdl_len[i] = c.request_size;
            end
         end
      endcase
      return r;
   endfunction

   task automatic random_gap();
      int unsigned n;
      if (!stall_en || $urandom_range(3) != 0) begin
         return;
      end
      n = ($urandom_range(15) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
      req.valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // valid stays high after a transaction until a gap, a drain or the next one
   task automatic send_op(opcode_type op, logic [31:0] size, logic [31:0] addr);
      alloc_cmd_type c;
      random_gap();
      req.valid <= 1'b1;
      req.opcode <= op;
      req.request_size <= size;
      req.block_address <= addr;
      do @(posedge clock); while (!req.ready);
      c.opcode = op;
      c.request_size = size;
      c.block_address = addr;
      pending_rsp.push_back(predict_region_op(c));
      n_sent++;
      op_seen[op]++;
      @(negedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      drain();
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= value;
      do @(posedge clock); while (!csr.ready);
      if (idx == CSR_TOP) begin
         mdl_top = value;
      end else begin
         mdl_init_len = value;
         table_reload();
      end
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   // response checker
   initial begin
      alloc_rsp_type e;
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            if (pending_rsp.size() == 0) begin
               $display("%t unexpected response value=%h status=%0d", $time,
                        rsp.result_value, rsp.status);
               n_errors++;
            end else begin
               e = pending_rsp.pop_front();
               n_checked++;
               if (rsp.result_value !== e.result_value) begin
                  $display("%t result_value expected %h actual %h", $time,
                           e.result_value, rsp.result_value);
                  n_errors++;
               end
               if (rsp.status !== e.status) begin
                  $display("%t status expected %0d actual %0d", $time, e.status, rsp.status);
                  n_errors++;
               end
            end
         end
         @(negedge clock);
         if (!stall_en) begin
            rsp.ready <= 1'b1;
         end else if ($urandom_range(49) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(30, 8)) @(negedge clock);
            rsp.ready <= 1'b1;
         end else begin
            rsp.ready <= ($urandom_range(3) != 0);
         end
      end
   end

   function automatic logic [31:0] pick_base();
      if (mdl_count != 0 && $urandom_range(9) != 0) begin
         return mdl_base[$urandom_range(mdl_count - 1)];
      end
      return $urandom();
   endfunction

   function automatic logic [31:0] pick_size();
      case ($urandom_range(9))
         0: return $urandom();
         1: return 32'h8000_0000 | $urandom();
         2: return '0;
         default: return $urandom_range(32'h3000);
      endcase
   endfunction

   task automatic test_directed();
      send_op(OP_QUERY, '0, '0);
      send_op(OP_ALLOC, 32'h0, '0);
      send_op(OP_ALLOC, 32'h100, '0);
      send_op(OP_ALLOC, 32'h8000_0000, '0);
      send_op(OP_ALLOC, 32'hFFFF_FFFF, '0);
      send_op(OP_ALLOC, 32'h7FFF_FFFF, '0);
      send_op(OP_SHRINK, 32'h80, 32'h900);
      send_op(OP_SHRINK, 32'hFFFF_FFFF, 32'h900);
      send_op(OP_SHRINK, 32'h10, 32'hFFFF_FFFF);
      send_op(OP_FREE, '0, 32'h900);
      send_op(OP_FREE, '0, 32'h900);
      send_op(OP_FREE, '0, 32'h0);
      send_op(OP_QUERY, '0, '0);
      send_op(OP_FREE, '0, FirstBase);
      send_op(OP_QUERY, '0, '0);
      send_op(OP_ALLOC, 32'h40, '0);
      send_op(OP_FREE, '0, 32'h900);
      for (int i = 0; i < Depth + 1; i++) begin
         send_op(OP_ALLOC, 32'h10, '0);
      end
      send_op(OP_QUERY, '0, '0);
   endtask

   task automatic test_config_extremes();
      write_csr(CSR_TOP, 32'h0);
      send_op(OP_ALLOC, 32'h0, '0);
      send_op(OP_QUERY, '0, '0);
      write_csr(CSR_TOP, 32'hFFFF_FFFF);
      write_csr(CSR_LENGTH, 32'hFFFF_FFFF);
      send_op(OP_QUERY, '0, '0);
      send_op(OP_ALLOC, 32'h10, '0);
      send_op(OP_ALLOC, 32'h7FFF_FFFF, '0);
      write_csr(CSR_LENGTH, 32'h0);
      send_op(OP_ALLOC, 32'h0, '0);
      send_op(OP_ALLOC, 32'h0, '0);
      send_op(OP_FREE, '0, FirstBase);
      send_op(OP_SHRINK, '0, FirstBase);
      send_op(OP_QUERY, '0, '0);
   endtask

   task automatic test_random(int unsigned n_items, logic [31:0] top, logic [31:0] len);
      opcode_type op;
      write_csr(CSR_TOP, top);
      write_csr(CSR_LENGTH, len);
      for (int i = 0; i < n_items; i++) begin
         case ($urandom_range(9))
            0, 1, 2, 3: op = OP_ALLOC;
            4: op = OP_QUERY;
            5, 6, 7: op = OP_FREE;
            default: op = OP_SHRINK;
         endcase
         if (i == n_items / 2) begin
            drain();
         end
         send_op(op, (op == OP_SHRINK && $urandom_range(1)) ?
                 $urandom_range(32'h200) : pick_size(), pick_base());
      end
   endtask

   initial begin
      req.valid = 1'b0;
      req.opcode = OP_ALLOC;
      req.request_size = '0;
      req.block_address = '0;
      csr.valid = 1'b0;
      csr.index = CSR_TOP;
      csr.data = '0;
      mdl_top = TopReset;
      mdl_init_len = LengthReset;
      table_reload();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_config_extremes();
      test_random(300, TopReset, LengthReset);
      stall_en = 1'b0;
      test_random(150, 32'h0000_4000, 32'h40);
      stall_en = 1'b1;
      test_random(200, 32'hFFFF_FFFF, 32'h8000_0000);
      test_random(250, $urandom(), $urandom_range(32'h1000));
      drain();

      $display("Sent %0d operations (alloc %0d, query %0d, free %0d, shrink %0d),",
               n_sent, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
      $display("checked %0d responses; %0d successful allocations, %0d with table full.",
               n_checked, n_alloc_ok, n_full);
      if (n_errors == 0 && pending_rsp.size() == 0) begin
         $display("first_fit_region_allocator test passed");
      end else begin
         $display("first_fit_region_allocator test failed");
      end
      $finish;
   end
endmodule

[sim.f]
rtl/core/ffra_pkg.sv
rtl/core/ffra_if.sv
rtl/core/ffra_datapath.sv
rtl/core/ffra_control.sv
rtl/core/first_fit_region_allocator.sv
test/tb_ffra_pkg.sv
test/tb_first_fit_region_allocator.sv
